// ----- hw/rtl/abfm_pkg.sv -----
// ----------------------------------------------------------------------------
// abfm_pkg
// shared types and constants of the adaptive bigram frequency model
// ----------------------------------------------------------------------------
package abfm_pkg;

  localparam int SYM_W     = 8;
  localparam int VAL_W     = 14;
  localparam int CFG_IDX_W = 1;

  localparam logic [VAL_W-1:0] VAL_MAX = 14'd16383;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL    = 1'd1;

  // item modes
  localparam logic MODE_SYMBOL = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [SYM_W-1:0] symbol;
  } abfm_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] cum_low;
    logic [VAL_W-1:0] cum_high;
    logic [VAL_W-1:0] total;
  } abfm_out_t;

  typedef struct packed {
    logic             adapt_enable;
    logic [VAL_W-1:0] max_total;
  } abfm_cfg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LK_HI,
    S_LK_LO,
    S_LK_TOT,
    S_LK_DONE,
    S_CTX0_RD,
    S_CTX0_WAIT,
    S_HALVE,
    S_HALVE_END,
    S_INC,
    S_INC_END
  } abfm_state_t;

endpackage

// ----- hw/rtl/adaptive_bigram_frequency_model.sv -----
// ----------------------------------------------------------------------------
// adaptive_bigram_frequency_model
// order-1 adaptive symbol frequency model for an arithmetic coder
// ----------------------------------------------------------------------------
// After reset the block loads uniform counts into every entry of its tables,
// with busy high; config writes wait for busy to drop, so a register never
// changes under an item. A clear item, or a symbol at or above NUM_SYMBOLS,
// is absorbed in its accept cycle and busy stays low. A coded symbol is looked
// up through S_LK_HI, S_LK_LO, S_LK_TOT and S_LK_DONE, and its result shows on
// out_data with a one-cycle out_valid strobe registered at the end of
// S_LK_DONE; the receiver must take it then, there is no stall.
// With adaptation on, busy then stays high while the tables are walked one
// entry per cycle through a single read port: the increment walk covers
// entries 0 to sym, led by a halving walk over every entry when the context
// total reaches max_total, and when the current context is not 0 the same
// check and walks follow for context 0 after S_CTX0_RD and S_CTX0_WAIT.
// ----------------------------------------------------------------------------
module adaptive_bigram_frequency_model
  import abfm_pkg::*;
#(
  parameter int NUM_SYMBOLS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // item transaction
  input  logic                 start,
  output logic                 busy,
  input  abfm_in_t             in_data,
  // result transaction
  output logic                 out_valid,
  output abfm_out_t            out_data,
  // configuration transaction
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);

  // configuration registers
  logic             adapt_enable_r, adapt_enable_nxt;
  logic [VAL_W-1:0] max_total_r, max_total_nxt;
  abfm_cfg_t        cfg;

  // writes are taken only between items, the walks read the registers
  assign cfg_ready = !busy;

  always_comb begin
    adapt_enable_nxt = adapt_enable_r;
    max_total_nxt    = max_total_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ADAPT_ENABLE: adapt_enable_nxt = cfg_data[0];
        CFG_MAX_TOTAL:    max_total_nxt    = cfg_data;
        default: begin
          adapt_enable_nxt = adapt_enable_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adapt_enable_r <= 1'b1;
      max_total_r    <= VAL_MAX;
    end else begin
      adapt_enable_r <= adapt_enable_nxt;
      max_total_r    <= max_total_nxt;
    end
  end

  assign cfg = '{adapt_enable: adapt_enable_r, max_total: max_total_r};

  // sequencer with the count and cumulative tables
  abfm_ctrl #(.NUM_SYMBOLS(NUM_SYMBOLS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .res_valid (out_valid),
    .res       (out_data)
  );

endmodule

// ----- hw/rtl/abfm_ram.sv -----
// ----------------------------------------------------------------------------
// abfm_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module abfm_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 14
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/abfm_ctrl.sv -----
// ----------------------------------------------------------------------------
// abfm_ctrl
// sequencer, count and cumulative tables, and the shared update adder
// ----------------------------------------------------------------------------
module abfm_ctrl
  import abfm_pkg::*;
#(
  parameter int NUM_SYMBOLS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  abfm_cfg_t cfg,
  input  logic      start,
  input  abfm_in_t  in_data,
  output logic      busy,
  output logic      res_valid,
  output abfm_out_t res
);

  localparam int NUM_CTX = NUM_SYMBOLS + 1;
  localparam int IDX_W   = $clog2(NUM_SYMBOLS);
  localparam int CTX_W   = $clog2(NUM_SYMBOLS + 1);
  localparam int DEPTH   = NUM_CTX * NUM_SYMBOLS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int SYMX_W  = SYM_W + 1;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SYMBOLS - 1);
  localparam logic [CTX_W-1:0] CTX_LAST = CTX_W'(NUM_SYMBOLS);

  abfm_state_t      state_r, state_nxt;
  logic [CTX_W-1:0] ctx_r, ctx_nxt;
  logic [CTX_W-1:0] bctx_r, bctx_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] widx_r, widx_nxt;
  logic [IDX_W-1:0] sym_r, sym_nxt;
  logic             pend_r, pend_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic [VAL_W-1:0] hi_r, hi_nxt;
  logic [VAL_W-1:0] lo_r, lo_nxt;
  abfm_out_t        res_r, res_nxt;
  logic             res_valid_r, res_valid_nxt;

  logic [ADDR_W-1:0] raddr, waddr;
  logic              cnt_we, cum_we;
  logic [VAL_W-1:0]  cnt_wdata, cum_wdata;
  logic [VAL_W-1:0]  cnt_rdata, cum_rdata;

  // shared adder
  logic [VAL_W-1:0] alu_a, alu_b, alu_sum;
  logic [VAL_W:0]   half_sum;
  logic [VAL_W-1:0] half;
  logic             walk_halve, walk_inc, over_limit;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [CTX_W-1:0] c,
                                                input logic [IDX_W-1:0] i);
    addr_of = ADDR_W'(c) * ADDR_W'(NUM_SYMBOLS) + ADDR_W'(i);
  endfunction

  abfm_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .DATA_W(VAL_W)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (waddr),
    .wdata (cnt_wdata),
    .raddr (raddr),
    .rdata (cnt_rdata)
  );

  abfm_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .DATA_W(VAL_W)) u_cum_ram (
    .clk   (clk),
    .we    (cum_we),
    .waddr (waddr),
    .wdata (cum_wdata),
    .raddr (raddr),
    .rdata (cum_rdata)
  );

  assign walk_halve = (state_r == S_HALVE) || (state_r == S_HALVE_END);
  assign walk_inc   = (state_r == S_INC) || (state_r == S_INC_END);
  assign half_sum   = {1'b0, cnt_rdata} + {{VAL_W{1'b0}}, 1'b1};
  assign half       = half_sum[VAL_W:1];
  assign alu_a      = walk_halve ? acc_r : cum_rdata;
  assign alu_b      = walk_halve ? half : VAL_W'(1);
  assign alu_sum    = alu_a + alu_b;
  assign over_limit = cum_rdata >= cfg.max_total;

  always_comb begin
    state_nxt     = state_r;
    ctx_nxt       = ctx_r;
    bctx_nxt      = bctx_r;
    idx_nxt       = idx_r;
    widx_nxt      = widx_r;
    sym_nxt       = sym_r;
    pend_nxt      = 1'b0;
    acc_nxt       = acc_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    res_nxt       = res_r;
    res_valid_nxt = 1'b0;
    raddr         = addr_of(bctx_r, idx_r);
    waddr         = addr_of(bctx_r, widx_r);
    cnt_we        = 1'b0;
    cum_we        = 1'b0;
    cnt_wdata     = cnt_rdata;
    cum_wdata     = alu_sum;

    // write-back stage of the table walks
    if (pend_r && walk_halve) begin
      cnt_we    = 1'b1;
      cnt_wdata = half;
      cum_we    = 1'b1;
      acc_nxt   = alu_sum;
    end
    if (pend_r && walk_inc) begin
      cum_we = 1'b1;
      if (widx_r == sym_r) begin
        cnt_we    = 1'b1;
        cnt_wdata = cnt_rdata + VAL_W'(1);
      end
    end

    case (state_r)
      S_CLEAR: begin
        waddr     = addr_of(bctx_r, idx_r);
        cnt_we    = 1'b1;
        cnt_wdata = VAL_W'(1);
        cum_we    = 1'b1;
        cum_wdata = VAL_W'(NUM_SYMBOLS) - VAL_W'(idx_r);
        if (idx_r == IDX_LAST) begin
          idx_nxt = '0;
          if (bctx_r == CTX_LAST) begin
            bctx_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            bctx_nxt = bctx_r + CTX_W'(1);
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          if (in_data.mode == MODE_CLEAR) begin
            ctx_nxt = '0;
          end else if (SYMX_W'(in_data.symbol) < SYMX_W'(NUM_SYMBOLS)) begin
            sym_nxt   = IDX_W'(in_data.symbol);
            idx_nxt   = IDX_W'(in_data.symbol);
            bctx_nxt  = ctx_r;
            state_nxt = S_LK_HI;
          end
        end
      end
      S_LK_HI: begin
        raddr     = addr_of(bctx_r, sym_r);
        state_nxt = S_LK_LO;
      end
      S_LK_LO: begin
        hi_nxt    = cum_rdata;
        raddr     = addr_of(bctx_r, (sym_r == IDX_LAST) ? sym_r : sym_r + IDX_W'(1));
        state_nxt = S_LK_TOT;
      end
      S_LK_TOT: begin
        lo_nxt    = (sym_r == IDX_LAST) ? '0 : cum_rdata;
        raddr     = addr_of(bctx_r, '0);
        state_nxt = S_LK_DONE;
      end
      S_LK_DONE: begin
        res_nxt       = '{cum_low: lo_r, cum_high: hi_r, total: cum_rdata};
        res_valid_nxt = 1'b1;
        if (!cfg.adapt_enable) begin
          ctx_nxt   = CTX_W'(sym_r) + CTX_W'(1);
          state_nxt = S_IDLE;
        end else if (over_limit) begin
          idx_nxt   = IDX_LAST;
          acc_nxt   = '0;
          state_nxt = S_HALVE;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_INC;
        end
      end
      S_CTX0_RD: begin
        raddr     = addr_of('0, '0);
        state_nxt = S_CTX0_WAIT;
      end
      S_CTX0_WAIT: begin
        if (over_limit) begin
          idx_nxt   = IDX_LAST;
          acc_nxt   = '0;
          state_nxt = S_HALVE;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_INC;
        end
      end
      S_HALVE: begin
        pend_nxt = 1'b1;
        widx_nxt = idx_r;
        if (idx_r == '0) begin
          state_nxt = S_HALVE_END;
        end else begin
          idx_nxt = idx_r - IDX_W'(1);
        end
      end
      S_HALVE_END: begin
        idx_nxt   = '0;
        state_nxt = S_INC;
      end
      S_INC: begin
        pend_nxt = 1'b1;
        widx_nxt = idx_r;
        if (idx_r == sym_r) begin
          state_nxt = S_INC_END;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_INC_END: begin
        if (bctx_r != '0) begin
          bctx_nxt  = '0;
          state_nxt = S_CTX0_RD;
        end else begin
          ctx_nxt   = CTX_W'(sym_r) + CTX_W'(1);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ctx_r       <= '0;
      bctx_r      <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctx_r       <= ctx_nxt;
      bctx_r      <= bctx_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    widx_r <= widx_nxt;
    sym_r  <= sym_nxt;
    acc_r  <= acc_nxt;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
    res_r  <= res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = res_valid_r;
  assign res       = res_r;

`ifndef ASSERT_OFF
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |=> !res_valid_r)
    else $error("result strobe longer than one cycle");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!cnt_we && !cum_we))
    else $error("table write while idle");

  a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_HALVE || state_r == S_HALVE_END ||
                state_r == S_INC || state_r == S_INC_END))
    else $error("write-back pending outside a table walk");

  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> (res_r.cum_high > res_r.cum_low) && (res_r.total >= res_r.cum_high))
    else $error("inconsistent cumulative range");
`endif

endmodule

// ----- dv/adaptive_bigram_frequency_model_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_bigram_frequency_model_test
// self-checking bench for the order-1 adaptive frequency model
// ----------------------------------------------------------------------------
// A queue of pending items feeds a clocked driver. The driver keeps a private
// copy of the count and cumulative tables, works out the coding range of
// every accepted symbol and queues it. A clocked monitor compares each result
// strobe with the oldest queued range. The run walks through several register
// settings (adaptation on and off, rescale limits from the largest down to a
// tiny one), starting with a short directed sequence and then mostly random
// strings that open with a context clear.
// ----------------------------------------------------------------------------
module adaptive_bigram_frequency_model_test;
  import abfm_pkg::*;

  localparam int NSYM = 256;
  // longest table walk of one item plus some margin
  localparam int SETTLE_CYCLES = 4 * NSYM + 64;
  // several times the clearing pass after reset
  localparam int STALL_LIMIT = 4 * (NSYM + 1) * NSYM;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  abfm_in_t             in_data   = '0;
  logic                 out_valid;
  abfm_out_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ADAPT_ENABLE;
  logic [VAL_W-1:0]     cfg_data  = '0;

  adaptive_bigram_frequency_model #(
    .NUM_SYMBOLS(NSYM)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // private copy of the model state: per-context counts and cumulative counts
  logic [VAL_W-1:0] freq     [0:NSYM][0:NSYM-1];
  logic [VAL_W-1:0] cum_freq [0:NSYM][0:NSYM];
  int unsigned      ctx_now;
  logic             adapt_on;
  logic [VAL_W-1:0] total_limit;

  abfm_in_t  items_waiting[$];
  abfm_out_t ranges_due[$];

  int gap_left     = 0;
  bit tight_flow   = 1'b0;
  int quiet_cycles = 0;
  int errors       = 0;
  int n_coded      = 0;
  int n_clears     = 0;
  int n_rescales   = 0;
  int n_ranges     = 0;
  int n_settings   = 0;

  // count one more occurrence of a symbol in a context, rescaling first when
  // the context total has reached the limit (or sits above a lowered one)
  function automatic void adapt_context(input int unsigned c, input int unsigned s);
    int unsigned acc;
    int unsigned half;
    if (cum_freq[c][0] >= total_limit) begin
      acc = 0;
      cum_freq[c][NSYM] = '0;
      // halve rounding up, rebuilding the cumulative counts from the top
      for (int i = NSYM - 1; i >= 0; i--) begin
        half = (int'(freq[c][i]) + 1) >> 1;
        freq[c][i] = half[VAL_W-1:0];
        acc += half;
        cum_freq[c][i] = acc[VAL_W-1:0];
      end
      n_rescales++;
    end
    freq[c][s] = freq[c][s] + 1'b1;
    // cumulative entries 0..s all cover this symbol
    for (int i = 0; i <= s; i++) cum_freq[c][i] = cum_freq[c][i] + 1'b1;
  endfunction

  // coding range of one item; returns 1 when the item yields a result
  function automatic bit predict_range(input abfm_in_t item, output abfm_out_t rng);
    int unsigned c;
    int unsigned s;
    c = ctx_now;
    s = 32'(item.symbol);
    rng = '0;
    if (item.mode == MODE_CLEAR) begin
      ctx_now = 0;
      n_clears++;
      return 1'b0;
    end
    if (s >= NSYM) return 1'b0;
    rng.cum_low  = cum_freq[c][s+1];
    rng.cum_high = cum_freq[c][s];
    rng.total    = cum_freq[c][0];
    if (adapt_on) begin
      adapt_context(c, s);
      // the start-of-string context learns from every symbol
      if (c != 0) adapt_context(0, s);
    end
    ctx_now = s + 1;
    n_coded++;
    return 1'b1;
  endfunction

  // item driver: a transaction is taken when start is high and busy is low
  always @(posedge clk) begin : feed_items
    abfm_out_t rng;
    bit        took;
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      took = start && !busy;
      if (took) begin
        if (predict_range(in_data, rng)) ranges_due.push_back(rng);
      end
      // start stays high across back-to-back items, one assignment per edge
      if (!start || took) begin
        if (gap_left != 0) begin
          start    <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (items_waiting.size() != 0) begin
          in_data  <= items_waiting.pop_front();
          start    <= 1'b1;
          gap_left <= tight_flow ? 0 : $urandom_range(0, 3);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string field, input logic [VAL_W-1:0] exp_v,
                               input logic [VAL_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
      errors++;
    end
  endtask

  // result monitor: each strobe is one transaction, no back-pressure exists
  always @(posedge clk) begin : check_ranges
    abfm_out_t want;
    if (rst_n && out_valid) begin
      if (ranges_due.size() == 0) begin
        $error("coding range %h with no coded symbol waiting for it", out_data);
        errors++;
      end else begin
        want = ranges_due.pop_front();
        compare_field("cum_low", want.cum_low, out_data.cum_low);
        compare_field("cum_high", want.cum_high, out_data.cum_high);
        compare_field("total", want.total, out_data.total);
        n_ranges++;
      end
    end
  end

  // cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic queue_item(input logic mode, input logic [SYM_W-1:0] sym);
    abfm_in_t item;
    item.mode   = mode;
    item.symbol = sym;
    items_waiting.push_back(item);
  endtask

  // register write transaction; only issued while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_ADAPT_ENABLE) adapt_on = val[0];
    else total_limit = val;
    cfg_valid <= 1'b0;
  endtask

  // hold the sender until every queued item is taken and every range is back
  task automatic wait_idle();
    while (items_waiting.size() != 0 || start || ranges_due.size() != 0) @(posedge clk);
  endtask

  task automatic start_phase(input logic adapt, input logic [VAL_W-1:0] limit,
                             input bit tight);
    wait_idle();
    // a symbol may still be walking the tables after its result
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_ADAPT_ENABLE, {{(VAL_W-1){1'b0}}, adapt});
    write_reg(CFG_MAX_TOTAL, limit);
    tight_flow = tight;
    n_settings++;
  endtask

  // mostly strings that open with a clear and draw from a narrow alphabet so
  // that counts pile up, with some stray symbols and random noise items
  task automatic queue_strings(input int n);
    int queued;
    int len;
    int base;
    queued = 0;
    while (queued < n) begin
      if ($urandom_range(0, 7) == 0) begin
        queue_item(1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 255)));
        queued++;
      end else begin
        queue_item(MODE_CLEAR, SYM_W'($urandom_range(0, 255)));
        queued++;
        base = $urandom_range(0, NSYM - 8);
        len  = $urandom_range(1, 12);
        for (int k = 0; k < len && queued < n; k++) begin
          if ($urandom_range(0, 3) == 0) begin
            queue_item(MODE_SYMBOL, SYM_W'($urandom_range(0, NSYM - 1)));
          end else begin
            queue_item(MODE_SYMBOL, SYM_W'(base + int'($urandom_range(0, 7))));
          end
          queued++;
        end
      end
    end
  endtask

  initial begin : stimulus
    // uniform tables after reset
    for (int c = 0; c <= NSYM; c++) begin
      for (int j = 0; j < NSYM; j++) begin
        freq[c][j]     = VAL_W'(1);
        cum_freq[c][j] = VAL_W'(NSYM - j);
      end
      cum_freq[c][NSYM] = '0;
    end
    ctx_now     = 0;
    adapt_on    = 1'b1;
    total_limit = VAL_MAX;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // largest limit, adaptation on, random gaps
    start_phase(1'b1, VAL_MAX, 1'b0);
    queue_item(MODE_CLEAR, 8'hFF);   // clear ignores its symbol
    queue_item(MODE_SYMBOL, 8'h00);  // lowest symbol at start of string
    queue_item(MODE_SYMBOL, 8'hFF);  // highest symbol
    queue_item(MODE_SYMBOL, 8'hFF);  // now in the highest context
    queue_item(MODE_SYMBOL, 8'h00);
    queue_item(MODE_SYMBOL, 8'h55);
    queue_item(MODE_SYMBOL, 8'hAA);
    queue_item(MODE_CLEAR, 8'hAA);
    queue_item(MODE_SYMBOL, 8'hFF);  // highest symbol in the start context
    queue_item(MODE_CLEAR, 8'h00);
    queue_item(MODE_CLEAR, 8'h00);   // back-to-back clears
    queue_item(MODE_SYMBOL, 8'h00);
    queue_item(MODE_SYMBOL, 8'h00);  // same context hit repeatedly
    queue_item(MODE_SYMBOL, 8'h00);
    queue_item(MODE_SYMBOL, 8'h80);
    queue_item(MODE_SYMBOL, 8'h01);
    queue_item(MODE_SYMBOL, 8'hFE);
    queue_item(MODE_CLEAR, 8'h00);
    queue_strings(140);

    // lowest legal limit: every update rescales, and the start context sits
    // above the new limit already; no idle cycles on the sender
    start_phase(1'b1, 14'd16, 1'b1);
    queue_strings(110);

    // frozen counts
    start_phase(1'b0, 14'd300, 1'b0);
    queue_strings(80);

    // mid limit, rescales after counts have grown
    start_phase(1'b1, 14'd300, 1'b0);
    queue_strings(110);

    // limit below the legal range still behaves
    start_phase(1'b1, 14'd3, 1'b1);
    queue_strings(50);

    start_phase(1'b1, VAL_MAX, 1'b0);
    queue_strings(40);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (ranges_due.size() != 0) begin
      $error("%0d coding ranges never arrived", ranges_due.size());
      errors++;
    end
    $display("coded %0d symbols and %0d context clears over %0d register settings",
             n_coded, n_clears, n_settings);
    $display("%0d ranges checked, %0d context rescales predicted, %0d errors",
             n_ranges, n_rescales, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
